/* hdl/stnf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stnf_pkg
// Shared constants and functions for the spherical three-nearest feature update.
// ----------------------------------------------------------------------------
package stnf_pkg;
  localparam int unsigned NumPointsDef = 4096;
  localparam int unsigned IdxW  = 12;
  localparam int unsigned DistW = 17;
  localparam int unsigned CrdW  = 16;
  localparam logic [DistW-1:0] DistOne = 17'd65536;
  localparam logic [35:0] PiQ30 = 36'd3373259426;
  localparam logic [31:0] Q30One = 32'd1073741824;
  localparam logic ActOffer = 1'b0;
  localparam logic ActRead  = 1'b1;

  // Horner divisors d = (2k-1)*2k for k = 1..8, done as a reciprocal
  // multiply: with s = 32 + ceil(log2(d)) and M = floor(2^s/d) + 1,
  // (n*M) >> s is floor(n/d) for every 32-bit n.
  function automatic logic [32:0] horner_recip(input logic [2:0] km1);
    logic [32:0] m;
    case (km1)
      3'd0: m = 33'((64'd1 << 33) / 64'd2 + 64'd1);
      3'd1: m = 33'((64'd1 << 36) / 64'd12 + 64'd1);
      3'd2: m = 33'((64'd1 << 37) / 64'd30 + 64'd1);
      3'd3: m = 33'((64'd1 << 38) / 64'd56 + 64'd1);
      3'd4: m = 33'((64'd1 << 39) / 64'd90 + 64'd1);
      3'd5: m = 33'((64'd1 << 40) / 64'd132 + 64'd1);
      3'd6: m = 33'((64'd1 << 40) / 64'd182 + 64'd1);
      default: m = 33'((64'd1 << 40) / 64'd240 + 64'd1);
    endcase
    return m;
  endfunction

  function automatic logic [5:0] horner_shift(input logic [2:0] km1);
    logic [5:0] s;
    case (km1)
      3'd0: s = 6'd33;
      3'd1: s = 6'd36;
      3'd2: s = 6'd37;
      3'd3: s = 6'd38;
      3'd4: s = 6'd39;
      default: s = 6'd40;
    endcase
    return s;
  endfunction
endpackage
`default_nettype wire

/* hdl/spherical_three_nearest_feature_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spherical_three_nearest_feature_update
// Keeps the three smallest angular distances per point on a unit sphere.
// ----------------------------------------------------------------------------
// One item is in flight at a time: input stalls from the accepting edge until
// the result has been taken. A read item passes RAM read, triple select,
// result register and handshake before the next accept. An offer runs the
// angle unit: a bisection of 16 or 17 steps over the Q1.16 distance, each
// step picking the boundary, reducing the angle, squaring it, then running
// 8 Horner terms of multiply, reciprocal divide and subtract. An out_stall
// holds the result and keeps input stalled. The triple store is one
// synchronous RAM of NUM_POINTS entries, read once per item and written back
// only when an offer is inserted, by a single sequencer, so accesses never
// overlap. After reset the block sweeps the RAM writing 1.0 into every entry,
// one entry a cycle, and stalls input meanwhile.
// ----------------------------------------------------------------------------
module spherical_three_nearest_feature_update #(
  parameter int unsigned NUM_POINTS = stnf_pkg::NumPointsDef
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic in_action,
  input  wire logic [stnf_pkg::IdxW-1:0] in_point_index,
  input  wire logic signed [stnf_pkg::CrdW-1:0] in_point_x,
  input  wire logic signed [stnf_pkg::CrdW-1:0] in_point_y,
  input  wire logic signed [stnf_pkg::CrdW-1:0] in_point_z,
  input  wire logic signed [stnf_pkg::CrdW-1:0] in_feature_x,
  input  wire logic signed [stnf_pkg::CrdW-1:0] in_feature_y,
  input  wire logic signed [stnf_pkg::CrdW-1:0] in_feature_z,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic [stnf_pkg::DistW-1:0] out_nearest_first,
  output logic [stnf_pkg::DistW-1:0] out_nearest_second,
  output logic [stnf_pkg::DistW-1:0] out_nearest_third,
  output logic [stnf_pkg::DistW-1:0] out_offered_distance,
  output logic      out_was_inserted
);
  import stnf_pkg::*;

  localparam int unsigned AW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_DOT   = 11'b00000000100,
    S_MID   = 11'b00000001000,
    S_X     = 11'b00000010000,
    S_X2    = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_DIV   = 11'b00010000000,
    S_CMP   = 11'b00100000000,
    S_UPD   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_t;

  state_t state_r;
  logic [AW-1:0] clr_r;
  logic [DistW*3-1:0] mem [NUM_POINTS];
  logic [DistW*3-1:0] rd_r;

  logic act_r, vld_r;
  logic [AW-1:0] idx_r;
  logic signed [CrdW-1:0] px_r, py_r, pz_r, fx_r, fy_r, fz_r;
  logic signed [33:0] dot_r;   // 4*clamped dot, Q.30
  logic [16:0] lo_r, hi_r, mid_m;
  logic [17:0] m_r;            // reduced angle index
  logic neg_r;
  logic [31:0] x_r, x2_r;
  logic signed [32:0] r_r;
  logic [2:0] k_r;
  logic [31:0] num_r;
  logic [31:0] quo_r;
  logic [DistW-1:0] t0_r, t1_r, t2_r, dist_r;
  logic ins_r;
  logic [DistW-1:0] t0_nxt, t1_nxt, t2_nxt;
  logic ins_nxt;

  logic accept;
  assign in_stall = (state_r != S_IDLE);
  assign accept = in_valid && !in_stall;

  logic signed [33:0] dot_full;
  assign dot_full = 34'(px_r * fx_r) + 34'(py_r * fy_r) + 34'(pz_r * fz_r);

  logic [53:0] xprod;
  assign xprod = 54'(PiQ30) * 54'(m_r);
  logic [63:0] sq;
  assign sq = 64'(x_r) * 64'(x_r);
  logic [65:0] hm;
  assign hm = 66'(x2_r) * 66'($unsigned(r_r));
  logic [64:0] qprod;
  assign qprod = 65'(num_r) * 65'(horner_recip(k_r));

  // Horner term result; after the k=1 term this is the quadrant cosine
  logic signed [32:0] r_new;
  assign r_new = 33'(Q30One) - 33'(quo_r);

  logic signed [33:0] cosv;
  assign cosv = neg_r ? -34'(r_new) : 34'(r_new);
  assign mid_m = 17'((18'(lo_r) + 18'(hi_r)) >> 1);

  // sorted insert: strictly below third enters, ties go after equal values
  always_comb begin
    t0_nxt = DistOne;
    t1_nxt = DistOne;
    t2_nxt = DistOne;
    ins_nxt = 1'b0;
    if (vld_r) begin
      t0_nxt = rd_r[DistW-1:0];
      t1_nxt = rd_r[2*DistW-1:DistW];
      t2_nxt = rd_r[3*DistW-1:2*DistW];
      if (act_r == ActOffer && dist_r < rd_r[3*DistW-1:2*DistW]) begin
        ins_nxt = 1'b1;
        if (dist_r < rd_r[2*DistW-1:DistW]) begin
          t2_nxt = rd_r[2*DistW-1:DistW];
          if (dist_r < rd_r[DistW-1:0]) begin
            t1_nxt = rd_r[DistW-1:0];
            t0_nxt = dist_r;
          end else begin
            t1_nxt = dist_r;
          end
        end else begin
          t2_nxt = dist_r;
        end
      end
    end
  end

  // write-back of the sorted triple on the first cycle of S_OUT, if inserted
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) begin
      mem[clr_r] <= {DistOne, DistOne, DistOne};
    end else if (state_r == S_OUT && !out_valid && ins_r) begin
      mem[idx_r] <= {t2_r, t1_r, t0_r};
    end
    if (state_r == S_DOT) rd_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == NUM_POINTS - 1) state_r <= S_IDLE;
        end
        S_IDLE: if (accept) begin
          act_r <= in_action;
          vld_r <= 32'(in_point_index) < NUM_POINTS;
          idx_r <= AW'(in_point_index);
          px_r <= in_point_x; py_r <= in_point_y; pz_r <= in_point_z;
          fx_r <= in_feature_x; fy_r <= in_feature_y; fz_r <= in_feature_z;
          state_r <= S_DOT;
        end
        S_DOT: begin
          if (dot_full > 34'sd268435456) dot_r <= 34'sd1073741824;
          else if (dot_full < -34'sd268435456) dot_r <= -34'sd1073741824;
          else dot_r <= dot_full <<< 2;
          lo_r <= '0; hi_r <= DistOne;
          state_r <= (act_r == ActOffer) ? S_MID : S_UPD;
        end
        S_MID: begin
          if (lo_r < hi_r) begin
            if ({mid_m, 1'b1} > 18'(DistOne)) begin
              m_r <= 18'd131072 - {mid_m, 1'b1}; neg_r <= 1'b1;
            end else begin
              m_r <= {mid_m, 1'b1}; neg_r <= 1'b0;
            end
            state_r <= S_X;
          end else begin
            dist_r <= lo_r;
            state_r <= S_UPD;
          end
        end
        S_X: begin
          x_r <= 32'(xprod >> 17);
          state_r <= S_X2;
        end
        S_X2: begin
          x2_r <= 32'(sq >> 30);
          r_r <= 33'(Q30One);
          k_r <= 3'd7;
          state_r <= S_MUL;
        end
        S_MUL: begin
          num_r <= 32'(hm >> 30);
          state_r <= S_DIV;
        end
        S_DIV: begin
          quo_r <= 32'(qprod >> horner_shift(k_r));
          state_r <= S_CMP;
        end
        S_CMP: begin
          r_r <= r_new;
          if (k_r == 3'd0) begin
            // last term done: a cosine above the dot moves the bound up
            if (cosv > dot_r) lo_r <= mid_m + 17'd1;
            else hi_r <= mid_m;
            state_r <= S_MID;
          end else begin
            k_r <= k_r - 3'd1;
            state_r <= S_MUL;
          end
        end
        S_UPD: begin
          t0_r <= t0_nxt;
          t1_r <= t1_nxt;
          t2_r <= t2_nxt;
          ins_r <= ins_nxt;
          if (act_r == ActRead) dist_r <= '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin
            out_valid <= 1'b0; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_nearest_first = t0_r;
  assign out_nearest_second = t1_r;
  assign out_nearest_third = t2_r;
  assign out_offered_distance = dist_r;
  assign out_was_inserted = ins_r;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("accept while busy");
  a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT) else $error("result outside output phase");
  a_read_no_ins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && act_r == ActRead |-> !out_was_inserted) else $error("read inserted");
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_nearest_first <= out_nearest_second &&
    out_nearest_second <= out_nearest_third) else $error("triple unsorted");
`endif
endmodule
`default_nettype wire
